>>> design/ptl_pkg.sv
`timescale 1ns / 1ps
package ptl_pkg;

  // table size and derived widths
  localparam int SLOTS    = 16;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int STEP_W   = $clog2(SLOTS + 1);
  localparam int HANDLE_W = 5;
  localparam int COUNT_W  = 32;
  localparam int TICK_W   = 64;

  // operation codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_CREATE = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_FIRED  = 2'd0;
  localparam logic [1:0] KIND_CREATE = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_REFUSED   = 2'd1;
  localparam logic [1:0] ST_REMOVED   = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;

  typedef struct packed {
    logic [1:0]          operation;
    logic                has_callback;
    logic [COUNT_W-1:0]  interval;
    logic [HANDLE_W-1:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [HANDLE_W-1:0] timer_handle;
    logic [1:0]          status;
    logic [TICK_W-1:0]   tick_value;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] reload;
    logic [COUNT_W-1:0] down;
  } timer_word_t;

  localparam int TIMER_W = $bits(timer_word_t);

  // slot occupancy commands
  typedef struct packed {
    logic              set_en;
    logic [SLOT_W-1:0] set_slot;
    logic              clr_en;
    logic [SLOT_W-1:0] clr_slot;
  } used_cmd_t;

  // lowest free slot report
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } alloc_stat_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [HANDLE_W-1:0] h);
    logic [HANDLE_W-1:0] idx;
    idx = h - HANDLE_W'(1);
    return SLOT_W'(idx);
  endfunction

  function automatic logic [HANDLE_W-1:0] handle_of(input logic [SLOT_W-1:0] s);
    return HANDLE_W'(s) + HANDLE_W'(1);
  endfunction

endpackage

>>> design/periodic_timer_list_core.sv
`timescale 1ns / 1ps
// channel | ports                  | handshake
// --------+------------------------+------------------------------------------
// input   | start, busy, in_item   | beat taken at a clock edge with start high
//         |                        | and busy low
// result  | out_valid, out_item    | one-cycle strobe, no back-pressure
//
// a tick walks every timer on the chain through the link memory, then passes
// through S_FLUSH when any timer fired
// a create passes through S_LINK when the new timer is linked behind a tail
// a delete walks the chain entries up to the match
// reset is synchronous, active low; timer and link memories need no clearing
// results appear the cycle after they are decided and cannot be stalled
module periodic_timer_list_core
  import ptl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TICK  = 3'd1;
  localparam logic [2:0] S_LINK  = 3'd2;
  localparam logic [2:0] S_DEL   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  // control state
  logic [2:0]          state_r, state_nxt;
  logic [HANDLE_W-1:0] head_r, head_nxt;
  logic [HANDLE_W-1:0] tail_r, tail_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [HANDLE_W-1:0] cur_r, cur_nxt;
  logic [HANDLE_W-1:0] prev_r, prev_nxt;
  logic [HANDLE_W-1:0] target_r, target_nxt;
  logic [STEP_W-1:0]   steps_r, steps_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [HANDLE_W-1:0] pend_hdl_r, pend_hdl_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  // memory ports
  logic                rd_en;
  logic [SLOT_W-1:0]   rd_addr;
  logic                t_wr_en;
  logic [SLOT_W-1:0]   t_wr_addr;
  timer_word_t         t_wr_data;
  logic [TIMER_W-1:0]  t_rd_raw;
  timer_word_t         t_rd;
  logic                l_wr_en;
  logic [SLOT_W-1:0]   l_wr_addr;
  logic [HANDLE_W-1:0] l_wr_data;
  logic [HANDLE_W-1:0] l_rd;

  used_cmd_t           used_cmd;
  alloc_stat_t         alloc;

  // walk helpers
  logic [COUNT_W-1:0]  dec;
  logic [STEP_W-1:0]   steps_inc;
  logic                walk_on;
  logic [HANDLE_W-1:0] new_hdl;

  ptl_ram #(
    .DATA_W (TIMER_W),
    .DEPTH  (SLOTS)
  ) u_timer_ram (
    .clk     (clk),
    .wr_en   (t_wr_en),
    .wr_addr (t_wr_addr),
    .wr_data (t_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (t_rd_raw)
  );

  ptl_ram #(
    .DATA_W (HANDLE_W),
    .DEPTH  (SLOTS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (l_wr_en),
    .wr_addr (l_wr_addr),
    .wr_data (l_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (l_rd)
  );

  ptl_slot_alloc u_alloc (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (used_cmd),
    .stat  (alloc)
  );

  assign t_rd      = timer_word_t'(t_rd_raw);
  assign dec       = t_rd.down - COUNT_W'(1);
  assign steps_inc = steps_r + STEP_W'(1);
  // keep walking while the next link is a live handle and the step bound holds
  assign walk_on   = (l_rd != '0) && (l_rd <= HANDLE_W'(SLOTS))
                     && (steps_inc < STEP_W'(SLOTS));
  assign new_hdl   = handle_of(alloc.slot);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    tick_nxt       = tick_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    target_nxt     = target_r;
    steps_nxt      = steps_r;
    pend_valid_nxt = pend_valid_r;
    pend_hdl_nxt   = pend_hdl_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    t_wr_en        = 1'b0;
    t_wr_addr      = '0;
    t_wr_data      = '0;
    l_wr_en        = 1'b0;
    l_wr_addr      = '0;
    l_wr_data      = '0;
    used_cmd       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_item.operation)
            OP_TICK: begin
              tick_nxt = tick_r + TICK_W'(1);
              if (head_r != '0 && head_r <= HANDLE_W'(SLOTS)) begin
                rd_en          = 1'b1;
                rd_addr        = slot_of(head_r);
                cur_nxt        = head_r;
                steps_nxt      = '0;
                pend_valid_nxt = 1'b0;
                state_nxt      = S_TICK;
              end
            end
            OP_CREATE: begin
              out_valid_nxt           = 1'b1;
              out_item_nxt            = '0;
              out_item_nxt.kind       = KIND_CREATE;
              out_item_nxt.last       = 1'b1;
              if (!in_item.has_callback || !alloc.found) begin
                out_item_nxt.status = ST_REFUSED;
              end else begin
                out_item_nxt.status       = ST_OK;
                out_item_nxt.timer_handle = new_hdl;
                t_wr_en          = 1'b1;
                t_wr_addr        = alloc.slot;
                t_wr_data.reload = in_item.interval;
                t_wr_data.down   = in_item.interval;
                l_wr_en          = 1'b1;
                l_wr_addr        = alloc.slot;
                l_wr_data        = '0;
                used_cmd.set_en   = 1'b1;
                used_cmd.set_slot = alloc.slot;
                tail_nxt          = new_hdl;
                if (tail_r == '0) begin
                  head_nxt = new_hdl;
                end else begin
                  // old tail gets its link in the next cycle
                  prev_nxt  = tail_r;
                  cur_nxt   = new_hdl;
                  state_nxt = S_LINK;
                end
              end
            end
            OP_DELETE: begin
              if (in_item.handle == '0 || head_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt        = '0;
                out_item_nxt.kind   = KIND_DELETE;
                out_item_nxt.status = ST_INVALID;
                out_item_nxt.last   = 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = slot_of(head_r);
                cur_nxt    = head_r;
                prev_nxt   = '0;
                steps_nxt  = '0;
                target_nxt = in_item.handle;
                state_nxt  = S_DEL;
              end
            end
            default: begin
              // unused code: no effect, no result
            end
          endcase
        end
      end

      S_LINK: begin
        l_wr_en   = 1'b1;
        l_wr_addr = slot_of(prev_r);
        l_wr_data = cur_r;
        state_nxt = S_IDLE;
      end

      S_TICK: begin
        // data for cur_r is on the memory outputs this cycle
        if (t_rd.reload != '0) begin
          t_wr_en   = 1'b1;
          t_wr_addr = slot_of(cur_r);
          t_wr_data.reload = t_rd.reload;
          if (dec == '0) begin
            t_wr_data.down = t_rd.reload;
            // a fire releases the one held back before it
            if (pend_valid_r) begin
              out_valid_nxt             = 1'b1;
              out_item_nxt              = '0;
              out_item_nxt.kind         = KIND_FIRED;
              out_item_nxt.timer_handle = pend_hdl_r;
              out_item_nxt.status       = ST_OK;
              out_item_nxt.tick_value   = tick_r;
              out_item_nxt.last         = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_hdl_nxt   = cur_r;
          end else begin
            t_wr_data.down = dec;
          end
        end
        if (walk_on) begin
          rd_en     = 1'b1;
          rd_addr   = slot_of(l_rd);
          cur_nxt   = l_rd;
          steps_nxt = steps_inc;
        end else if (pend_valid_nxt) begin
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_FLUSH: begin
        out_valid_nxt             = 1'b1;
        out_item_nxt              = '0;
        out_item_nxt.kind         = KIND_FIRED;
        out_item_nxt.timer_handle = pend_hdl_r;
        out_item_nxt.status       = ST_OK;
        out_item_nxt.tick_value   = tick_r;
        out_item_nxt.last         = 1'b1;
        pend_valid_nxt            = 1'b0;
        state_nxt                 = S_IDLE;
      end

      S_DEL: begin
        if (cur_r == target_r) begin
          // unlink: predecessor or head takes the successor
          if (prev_r == '0) begin
            head_nxt = l_rd;
          end else begin
            l_wr_en   = 1'b1;
            l_wr_addr = slot_of(prev_r);
            l_wr_data = l_rd;
          end
          if (tail_r == cur_r) begin
            tail_nxt = prev_r;
          end
          used_cmd.clr_en   = 1'b1;
          used_cmd.clr_slot = slot_of(cur_r);
          out_valid_nxt       = 1'b1;
          out_item_nxt        = '0;
          out_item_nxt.kind   = KIND_DELETE;
          out_item_nxt.status = ST_REMOVED;
          out_item_nxt.last   = 1'b1;
          state_nxt           = S_IDLE;
        end else if (walk_on) begin
          rd_en     = 1'b1;
          rd_addr   = slot_of(l_rd);
          prev_nxt  = cur_r;
          cur_nxt   = l_rd;
          steps_nxt = steps_inc;
        end else begin
          out_valid_nxt       = 1'b1;
          out_item_nxt        = '0;
          out_item_nxt.kind   = KIND_DELETE;
          out_item_nxt.status = ST_NOT_FOUND;
          out_item_nxt.last   = 1'b1;
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      tick_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      steps_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      tick_r       <= tick_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      steps_r      <= steps_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    target_r   <= target_nxt;
    pend_hdl_r <= pend_hdl_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> design/ptl_ram.sv
`timescale 1ns / 1ps
module ptl_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/ptl_slot_alloc.sv
`timescale 1ns / 1ps
module ptl_slot_alloc
  import ptl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  used_cmd_t   cmd,
  output alloc_stat_t stat
);

  logic [SLOTS-1:0] used_r;
  logic [SLOTS-1:0] used_nxt;

  always_comb begin
    used_nxt = used_r;
    if (cmd.set_en) begin
      used_nxt[cmd.set_slot] = 1'b1;
    end
    if (cmd.clr_en) begin
      used_nxt[cmd.clr_slot] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // lowest free slot wins
  always_comb begin
    stat = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        stat.found = 1'b1;
        stat.slot  = SLOT_W'(i);
      end
    end
  end

endmodule

>>> sim/tb_periodic_timer_list_core.sv
`timescale 1ns / 1ps
module tb_periodic_timer_list_core;
  import ptl_pkg::*;

  // operation code the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // a tick walks at most the whole chain; this covers it with margin
  localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
  // cycles without any beat before the run is abandoned
  localparam int QUIET_LIMIT = 3000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  periodic_timer_list_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // shadow of the timer table, advanced on every accepted input beat
  logic [COUNT_W-1:0]  reload_val [SLOTS];
  logic [COUNT_W-1:0]  down_cnt   [SLOTS];
  logic [HANDLE_W-1:0] next_hdl   [SLOTS];
  logic                slot_busy  [SLOTS];
  logic [HANDLE_W-1:0] chain_head = '0;
  logic [HANDLE_W-1:0] chain_tail = '0;
  logic [TICK_W-1:0]   tick_total = '0;

  // replies and fire events still owed by the block, oldest first
  out_item_t timer_events_due [$];

  int  items_sent = 0;      // beats offered and taken, stimulus side
  int  items_applied = 0;   // beats seen taken, shadow side
  int  mismatches = 0;
  int  events_checked = 0;
  int  n_ticks = 0, n_creates = 0, n_deletes = 0, n_fires = 0, max_fires = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;

  function automatic out_item_t make_event(input logic [1:0] kind,
                                           input logic [HANDLE_W-1:0] hdl,
                                           input logic [1:0] status,
                                           input logic [TICK_W-1:0] tv,
                                           input logic last);
    out_item_t ev;
    ev.kind         = kind;
    ev.timer_handle = hdl;
    ev.status       = status;
    ev.tick_value   = tv;
    ev.last         = last;
    return ev;
  endfunction

  // advance the shadow table by one beat and queue what it owes
  task automatic apply_timer_op(input in_item_t item);
    logic [HANDLE_W-1:0] cur, prev, hdl;
    out_item_t held;
    bit        have_held, found;
    int        s, steps, free_slot, fires;
    case (item.operation)
      OP_TICK: begin
        n_ticks++;
        tick_total = tick_total + TICK_W'(1);
        cur = chain_head;
        steps = 0;
        fires = 0;
        have_held = 1'b0;
        while (cur != 0 && cur <= SLOTS && steps < SLOTS) begin
          s = cur - 1;
          // interval zero never counts down
          if (reload_val[s] != 0) begin
            down_cnt[s] = down_cnt[s] - COUNT_W'(1);
            if (down_cnt[s] == 0) begin
              down_cnt[s] = reload_val[s];
              // hold each fire back one step so the final one can be flagged
              if (have_held) timer_events_due.push_back(held);
              held = make_event(KIND_FIRED, cur, ST_OK, tick_total, 1'b0);
              have_held = 1'b1;
              fires++;
            end
          end
          cur = next_hdl[s];
          steps++;
        end
        if (have_held) begin
          held.last = 1'b1;
          timer_events_due.push_back(held);
        end
        n_fires += fires;
        if (fires > max_fires) max_fires = fires;
      end
      OP_CREATE: begin
        n_creates++;
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!slot_busy[i]) free_slot = i;
        end
        if (!item.has_callback || free_slot < 0) begin
          timer_events_due.push_back(make_event(KIND_CREATE, '0, ST_REFUSED, '0, 1'b1));
        end else begin
          hdl = HANDLE_W'(free_slot + 1);
          reload_val[free_slot] = item.interval;
          down_cnt[free_slot]   = item.interval;
          next_hdl[free_slot]   = '0;
          slot_busy[free_slot]  = 1'b1;
          // append behind the current tail
          if (chain_tail == 0) chain_head = hdl;
          else next_hdl[slot_of(chain_tail)] = hdl;
          chain_tail = hdl;
          timer_events_due.push_back(make_event(KIND_CREATE, hdl, ST_OK, '0, 1'b1));
        end
      end
      OP_DELETE: begin
        n_deletes++;
        hdl = item.handle;
        if (hdl == 0 || chain_head == 0) begin
          timer_events_due.push_back(make_event(KIND_DELETE, '0, ST_INVALID, '0, 1'b1));
        end else begin
          prev = '0;
          cur = chain_head;
          steps = 0;
          found = 1'b0;
          while (!found && cur != 0 && cur <= SLOTS && steps < SLOTS) begin
            s = cur - 1;
            if (cur == hdl) begin
              if (prev == 0) chain_head = next_hdl[s];
              else next_hdl[slot_of(prev)] = next_hdl[s];
              if (chain_tail == cur) chain_tail = prev;
              slot_busy[s] = 1'b0;
              found = 1'b1;
            end else begin
              prev = cur;
              cur = next_hdl[s];
              steps++;
            end
          end
          timer_events_due.push_back(make_event(KIND_DELETE, '0,
                                                found ? ST_REMOVED : ST_NOT_FOUND,
                                                '0, 1'b1));
        end
      end
      default: begin
        // unknown operation: no state change, no result
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result beats are checked before the input beat of the same edge is
  // applied, so the order of the two never depends on the scheduler
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (timer_events_due.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %h",
                 $time, out_item);
        mismatches++;
      end else begin
        want = timer_events_due.pop_front();
        events_checked++;
        check_field("kind", 64'(want.kind), 64'(out_item.kind));
        check_field("timer_handle", 64'(want.timer_handle), 64'(out_item.timer_handle));
        check_field("status", 64'(want.status), 64'(out_item.status));
        check_field("tick_value", want.tick_value, out_item.tick_value);
        check_field("last", 64'(want.last), 64'(out_item.last));
      end
    end
    if (rst_n && start && busy === 1'b0) begin
      apply_timer_op(in_item);
      items_applied++;
    end
  end

  // watchdog: any beat in either direction keeps it quiet
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // offer one beat and hold it until taken; then maybe idle for a burst
  task automatic send_item(input in_item_t item);
    int gap;
    start   <= 1'b1;
    in_item <= item;
    items_sent++;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    // let the shadow table catch up before the next beat is chosen
    wait (items_applied == items_sent);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering beats until every owed result has come back
  task automatic wait_results_drained();
    start <= 1'b0;
    while (timer_events_due.size() != 0) @(posedge clk);
    // a tick with no fire is still walking the chain here
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t make_item(input logic [1:0] op, input logic cb,
                                         input logic [COUNT_W-1:0] interval,
                                         input logic [HANDLE_W-1:0] hdl);
    in_item_t it;
    it.operation    = op;
    it.has_callback = cb;
    it.interval     = interval;
    it.handle       = hdl;
    return it;
  endfunction

  // fields a beat does not use still get random values
  function automatic in_item_t noise_item();
    return make_item(2'($urandom), 1'($urandom), $urandom, 5'($urandom));
  endfunction

  function automatic logic [COUNT_W-1:0] pick_interval();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return COUNT_W'($urandom_range(1, 6));
    if (r == 6) return '0;
    if (r == 7) return COUNT_W'($urandom_range(7, 40));
    return $urandom;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_busy[i]) n++;
    end
    return n;
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_live_handle();
    int k;
    k = $urandom_range(0, live_count() - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_busy[i]) begin
        if (k == 0) return HANDLE_W'(i + 1);
        k--;
      end
    end
    return '0;
  endfunction

  task automatic clear_table();
    while (live_count() > 0) send_item(make_item(OP_DELETE, 1'b0, '0, pick_live_handle()));
  endtask

  // empty chain: tick with nothing, invalid deletes, refused create, unknown op
  task automatic test_empty_table();
    send_item(make_item(OP_TICK, 1'b0, '0, '0));
    send_item(make_item(OP_DELETE, 1'b1, '0, 5'd0));
    send_item(make_item(OP_DELETE, 1'b1, '0, 5'd7));
    send_item(make_item(OP_CREATE, 1'b0, 32'd5, '0));
    send_item(make_item(OP_UNUSED, 1'b1, '1, '1));
  endtask

  // intervals one, zero, two and all ones; two ticks fire those of one and two
  task automatic test_create_and_fire();
    send_item(make_item(OP_CREATE, 1'b1, 32'd1, '0));
    send_item(make_item(OP_CREATE, 1'b1, 32'd0, '0));
    send_item(make_item(OP_CREATE, 1'b1, 32'd2, '0));
    send_item(make_item(OP_CREATE, 1'b1, 32'hFFFF_FFFF, '1));
    send_item(make_item(OP_TICK, 1'b1, '1, '1));
    send_item(make_item(OP_TICK, 1'b0, '0, '0));
  endtask

  // not found above the table and on a free slot, null handle, then unlink
  // from the middle, the head and the tail, and reuse of the lowest slot
  task automatic test_delete_cases();
    send_item(make_item(OP_DELETE, 1'b0, '0, 5'd31));
    send_item(make_item(OP_DELETE, 1'b0, '0, 5'd17));
    send_item(make_item(OP_DELETE, 1'b0, '0, 5'd0));
    send_item(make_item(OP_DELETE, 1'b0, '0, 5'd9));
    send_item(make_item(OP_DELETE, 1'b0, '0, 5'd2));
    send_item(make_item(OP_DELETE, 1'b0, '0, 5'd1));
    send_item(make_item(OP_DELETE, 1'b0, '0, 5'd4));
    send_item(make_item(OP_CREATE, 1'b1, 32'd1, '0));
    send_item(make_item(OP_TICK, 1'b0, '0, '0));
    send_item(make_item(OP_TICK, 1'b0, '0, '0));
  endtask

  // every slot in use: refused create, sixteen fires per tick, relinking
  task automatic test_full_table();
    clear_table();
    repeat (SLOTS) send_item(make_item(OP_CREATE, 1'b1, 32'd1, '0));
    send_item(make_item(OP_CREATE, 1'b1, 32'd1, '0));
    repeat (2) send_item(make_item(OP_TICK, 1'b0, '0, '0));
    send_item(make_item(OP_DELETE, 1'b0, '0, 5'd16));
    send_item(make_item(OP_DELETE, 1'b0, '0, 5'd1));
    send_item(make_item(OP_DELETE, 1'b0, '0, 5'd8));
    repeat (3) send_item(make_item(OP_CREATE, 1'b1, pick_interval(), '0));
    repeat (4) send_item(make_item(OP_TICK, 1'b1, '0, '0));
    // churn on a full chain with short periods
    repeat (20) begin
      send_item(make_item(OP_DELETE, 1'b0, '0, pick_live_handle()));
      send_item(make_item(OP_CREATE, 1'b1, COUNT_W'($urandom_range(1, 3)), '0));
      send_item(make_item(OP_TICK, 1'b0, $urandom, '0));
    end
    clear_table();
  endtask

  task automatic run_mixed_traffic(input int n_items);
    in_item_t it;
    int done, r;
    done = 0;
    while (done < n_items) begin
      it = noise_item();
      r = $urandom_range(0, 99);
      if (r < 3) begin
        it.operation = OP_UNUSED;
      end else if (r < 48) begin
        it.operation = OP_TICK;
      end else if (r < 74) begin
        it.operation = OP_CREATE;
        it.has_callback = ($urandom_range(0, 9) != 0);
        it.interval = pick_interval();
      end else begin
        it.operation = OP_DELETE;
        if (live_count() > 0 && $urandom_range(0, 4) != 0) it.handle = pick_live_handle();
        else it.handle = 5'($urandom_range(0, 31));
      end
      if (it.operation != OP_UNUSED) done++;
      send_item(it);
    end
  endtask

  // random mix with idle bursts; halfway through the sender waits for the
  // block to empty before carrying on
  task automatic test_random_mix();
    run_mixed_traffic(150);
    wait_results_drained();
    run_mixed_traffic(150);
  endtask

  // last stretch with no idling at all
  task automatic test_back_to_back();
    idle_on = 1'b0;
    run_mixed_traffic(100);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_create_and_fire();
    test_delete_cases();
    test_full_table();
    test_random_mix();
    test_back_to_back();
    wait_results_drained();

    $display("covered %0d ticks, %0d creates, %0d deletes; %0d results checked",
             n_ticks, n_creates, n_deletes, events_checked);
    $display("%0d timer fires, up to %0d in a single tick", n_fires, max_fires);
    if (mismatches == 0 && timer_events_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
